// ----- hw/rtl/pfs_pkg.sv -----
// Shared types and constants for the packet field stepper.
package pfs_pkg;

    // Operating modes
    localparam logic [1:0] MODE_INC  = 2'd0;
    localparam logic [1:0] MODE_DEC  = 2'd1;
    localparam logic [1:0] MODE_CSUM = 2'd2;

    // Register indexes (byte address is 8 * index)
    localparam logic [2:0] REG_MODE         = 3'd0;
    localparam logic [2:0] REG_FIELD_MASK   = 3'd1;
    localparam logic [2:0] REG_RANGE_FIRST  = 3'd2;
    localparam logic [2:0] REG_RANGE_LAST   = 3'd3;
    localparam logic [2:0] REG_CHAIN_PERIOD = 3'd4;

    // Masks
    localparam logic [63:0] CSUM_MASK       = 64'hFFFF_0000_0000_0000;
    localparam logic [63:0] FIELD_MASK_RST  = 64'hFFFF_FFFF_0000_0000;
    localparam int          CSUM_SHIFT      = 48;

    // Nine IPv4 header words, checksum word excluded; word a in slot 0
    typedef logic [8:0][15:0] hdr_words_t;

    // Settings derived from the configuration registers
    typedef struct packed {
        logic [63:0] mask;
        logic [63:0] step;
        logic [63:0] lo;
        logic [63:0] hi;
        logic        rng;
    } cfg_derived_t;

endpackage

// ----- hw/rtl/packet_field_stepper.sv -----
// Top level of the packet field stepper: config registers, field update and beat pipeline.
//
// The block takes one packet beat per cycle while the output is not stalled and returns one
// result beat for each, through an input register and then the result register. The rate is set
// by the current-value update, a registered loop of one 64-bit add and a range compare
// that each beat must close before the next. Configuration is written over the APB port
// (64-bit registers at byte address 8*index); a write reloads the start value and clears
// the packet counter, and the derived range bounds are registered from the written registers.
// Reads return the register contents. Addresses beyond the register list are ignored.
module packet_field_stepper (
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] packet_word,
    input  logic [15:0] hdr_word_a,
    input  logic [15:0] hdr_word_b,
    input  logic [15:0] hdr_word_c,
    input  logic [15:0] hdr_word_d,
    input  logic [15:0] hdr_word_e,
    input  logic [15:0] hdr_word_f,
    input  logic [15:0] hdr_word_g,
    input  logic [15:0] hdr_word_h,
    input  logic [15:0] hdr_word_i,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] packet_word_out,
    output logic [63:0] field_value,
    output logic        chain_fire
);
    import pfs_pkg::*;

    // configuration registers
    logic [1:0]   mode_reg;
    logic [63:0]  field_mask_reg;
    logic [63:0]  range_first_reg;
    logic [63:0]  range_last_reg;
    logic [31:0]  chain_period_reg;
    logic         reload_pending_reg;

    // derived settings
    cfg_derived_t derived_reg;
    cfg_derived_t derived_next;
    logic [63:0]  start_next;
    logic [5:0]   step_pos;

    // state
    logic [63:0]  current_reg;
    logic [63:0]  current_next;
    logic [31:0]  apply_count_reg;
    logic [31:0]  phase_reg;
    logic [31:0]  phase_next;

    // pipeline
    logic         in_valid_reg;
    logic [63:0]  pkt_reg;
    hdr_words_t   hdr_reg;
    logic         out_valid_reg;
    logic [63:0]  pkt_out_reg;
    logic [63:0]  field_out_reg;
    logic         fire_reg;

    logic         cfg_write;
    logic [2:0]   cfg_index;
    logic         cfg_hit;
    logic         in_accept;
    logic         advance;
    logic         process;
    logic [63:0]  stepped;
    logic [63:0]  fv;
    logic [15:0]  csum;
    logic         fire;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[5:3];
    assign cfg_hit   = cfg_write && (cfg_index <= REG_CHAIN_PERIOD);

    // Read back the registers
    always_comb
    begin
        unique case (cfg_index)
            REG_MODE:         prdata = {62'd0, mode_reg};
            REG_FIELD_MASK:   prdata = field_mask_reg;
            REG_RANGE_FIRST:  prdata = range_first_reg;
            REG_RANGE_LAST:   prdata = range_last_reg;
            REG_CHAIN_PERIOD: prdata = {32'd0, chain_period_reg};
            default:          prdata = 64'd0;
        endcase
    end

    // Write the registers and flag a reload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg           <= MODE_INC;
            field_mask_reg     <= FIELD_MASK_RST;
            range_first_reg    <= 64'd0;
            range_last_reg     <= 64'd0;
            chain_period_reg   <= 32'd0;
            reload_pending_reg <= 1'b0;
        end
        else
        begin
            reload_pending_reg <= cfg_hit;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_MODE:         mode_reg         <= pwdata[1:0];
                    REG_FIELD_MASK:   field_mask_reg   <= pwdata;
                    REG_RANGE_FIRST:  range_first_reg  <= pwdata;
                    REG_RANGE_LAST:   range_last_reg   <= pwdata;
                    REG_CHAIN_PERIOD: chain_period_reg <= pwdata[31:0];
                    default:          ;
                endcase
            end
        end
    end

    // Derive mask, step and range bounds; the step is one-hot, so bounds are shifts
    always_comb
    begin
        derived_next.mask = (mode_reg == MODE_CSUM) ? CSUM_MASK : field_mask_reg;
        derived_next.step = derived_next.mask & (~derived_next.mask + 64'd1);
        step_pos = 6'd0;
        for (int i = 0; i < 64; i++)
        begin
            if (derived_next.step[i])
                step_pos = step_pos | 6'(i);
        end
        // an empty mask has a zero step and both bounds collapse to zero
        derived_next.lo  = (derived_next.step == 64'd0) ? 64'd0 : (range_first_reg << step_pos);
        derived_next.hi  = (derived_next.step == 64'd0) ? 64'd0 : (range_last_reg << step_pos);
        derived_next.rng = range_first_reg < range_last_reg;
        if (derived_next.rng && (mode_reg == MODE_INC))
            start_next = derived_next.hi;
        else if (derived_next.rng && (mode_reg == MODE_DEC))
            start_next = derived_next.lo;
        else
            start_next = 64'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            derived_reg.mask <= FIELD_MASK_RST;
            derived_reg.step <= 64'd1 << 32;
            derived_reg.lo   <= 64'd0;
            derived_reg.hi   <= 64'd0;
            derived_reg.rng  <= 1'b0;
        end
        else
        begin
            derived_reg <= derived_next;
        end
    end

    // Beat handshake
    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;
    assign process   = in_valid_reg && advance;

    // Capture the input beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_accept || (in_valid_reg && !advance);
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            pkt_reg <= packet_word;
            hdr_reg <= {hdr_word_i, hdr_word_h, hdr_word_g, hdr_word_f, hdr_word_e,
                        hdr_word_d, hdr_word_c, hdr_word_b, hdr_word_a};
        end
    end

    pfs_csum u_csum (
        .hdr  (hdr_reg),
        .csum (csum)
    );

    // Step the field value and wrap to the other end of the range; checksum mode loads the checksum, mode three holds
    always_comb
    begin
        stepped      = 64'd0;
        current_next = current_reg;
        unique case (mode_reg)
            MODE_INC:
            begin
                stepped = derived_reg.mask & (current_reg + derived_reg.step);
                if (derived_reg.rng && (stepped > derived_reg.hi || stepped < derived_reg.lo))
                    current_next = derived_reg.lo;
                else
                    current_next = stepped;
            end
            MODE_DEC:
            begin
                stepped = derived_reg.mask & (current_reg - derived_reg.step);
                if (derived_reg.rng && (stepped > derived_reg.hi || stepped < derived_reg.lo))
                    current_next = derived_reg.hi;
                else
                    current_next = stepped;
            end
            MODE_CSUM:
                current_next = {csum, 48'd0};
            default:
                current_next = current_reg;
        endcase
    end

    assign fv   = current_next & derived_reg.mask;
    assign fire = (chain_period_reg != 32'd0) && (phase_reg == 32'd0);

    // Track the count modulo the period; the count itself wraps at 2^32
    always_comb
    begin
        if (chain_period_reg == 32'd0)
            phase_next = 32'd0;
        else if ((apply_count_reg == 32'hFFFF_FFFF) || (phase_reg == chain_period_reg - 32'd1))
            phase_next = 32'd0;
        else
            phase_next = phase_reg + 32'd1;
    end

    // Hold the field state and counters; reload after a register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_reg     <= 64'd0;
            apply_count_reg <= 32'd0;
            phase_reg       <= 32'd0;
        end
        else if (cfg_hit)
        begin
            apply_count_reg <= 32'd0;
            phase_reg       <= 32'd0;
        end
        else if (reload_pending_reg)
        begin
            current_reg <= start_next;
        end
        else if (process)
        begin
            current_reg     <= current_next;
            apply_count_reg <= apply_count_reg + 32'd1;
            phase_reg       <= phase_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= process;
    end

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            pkt_out_reg   <= (pkt_reg & ~derived_reg.mask) | fv;
            field_out_reg <= fv;
            fire_reg      <= fire;
        end
    end

    assign out_valid       = out_valid_reg;
    assign packet_word_out = pkt_out_reg;
    assign field_value     = field_out_reg;
    assign chain_fire      = fire_reg;

`ifndef SYNTH
    // A beat that leaves the input register lands in the result register
    a_process_lands: assert property (@(posedge clk) disable iff (!rst_n)
        process |=> out_valid)
        else $error("processed beat did not reach the result register");

    // The input side stalls only with a beat held in the input register
    a_stall_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> !in_stall)
        else $error("input stalled with an empty input register");

    // The phase stays below a nonzero period
    a_phase_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (chain_period_reg != 32'd0) |-> (phase_reg < chain_period_reg))
        else $error("chain phase out of range");

    // No chain trigger is flagged with chaining disabled
    a_fire_period: assert property (@(posedge clk) disable iff (!rst_n)
        (process && (chain_period_reg == 32'd0)) |=> !chain_fire)
        else $error("chain trigger with zero period");

    // A register write clears the counter at once
    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_hit |=> (apply_count_reg == 32'd0) && (phase_reg == 32'd0))
        else $error("register write did not clear the packet counter");
`endif

endmodule

// ----- hw/rtl/pfs_csum.sv -----
// IPv4 header checksum over nine header words with a full end-around fold.
module pfs_csum (
    input  pfs_pkg::hdr_words_t hdr,
    output logic [15:0]         csum
);
    import pfs_pkg::*;

    logic [19:0] sum_ab;
    logic [19:0] sum_cd;
    logic [19:0] sum_ef;
    logic [19:0] sum_gh;
    logic [19:0] sum_all;
    logic [16:0] fold1;
    logic [15:0] fold2;

    // Add the nine words as a balanced tree
    assign sum_ab  = {4'd0, hdr[0]} + {4'd0, hdr[1]};
    assign sum_cd  = {4'd0, hdr[2]} + {4'd0, hdr[3]};
    assign sum_ef  = {4'd0, hdr[4]} + {4'd0, hdr[5]};
    assign sum_gh  = {4'd0, hdr[6]} + {4'd0, hdr[7]};
    assign sum_all = (sum_ab + sum_cd) + (sum_ef + sum_gh) + {4'd0, hdr[8]};

    // Fold the carries twice; the second fold cannot carry out again
    assign fold1 = {1'b0, sum_all[15:0]} + {13'd0, sum_all[19:16]};
    assign fold2 = fold1[15:0] + {15'd0, fold1[16]};

    assign csum = ~fold2;

endmodule

// ----- tb/packet_field_stepper_checker.sv -----
// Result checker for the packet field stepper: follows register writes, predicts and compares beats.
module packet_field_stepper_checker (
    input  logic                clk,
    input  logic                rst_n,
    // configuration port, watched only
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic                pready,
    input  logic [5:0]          paddr,
    input  logic [63:0]         pwdata,
    // input channel
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [63:0]         packet_word,
    input  pfs_pkg::hdr_words_t hdr_words,
    // output channel
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [63:0]         packet_word_out,
    input  logic [63:0]         field_value,
    input  logic                chain_fire,
    // status for the top
    output int                  fail_count,
    output int                  results_pending,
    output int                  results_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import pfs_pkg::*;

    typedef struct packed {
        logic [63:0] word;
        logic [63:0] value;
        logic        fire;
    } field_result_t;

    // Register copies and stepper state
    logic [1:0]  cfg_mode;
    logic [63:0] cfg_mask;
    logic [63:0] cfg_first;
    logic [63:0] cfg_last;
    logic [31:0] cfg_period;
    logic [63:0] cur_value;
    logic [31:0] beat_count;

    field_result_t due_results[$];
    field_result_t want;

    function automatic logic [63:0] active_mask();
        return (cfg_mode == MODE_CSUM) ? CSUM_MASK : cfg_mask;
    endfunction

    function automatic logic [15:0] header_checksum(input hdr_words_t w);
        logic [31:0] sum;
        sum = '0;
        for (int k = 0; k < 9; k++)
            sum += {16'd0, w[k]};
        // fold every carry back in, not just once
        while (sum > 32'h0000_FFFF)
            sum = (sum & 32'h0000_FFFF) + (sum >> 16);
        return ~sum[15:0];
    endfunction

    // Reload the start value and clear the packet counter
    task automatic reload_start();
        logic [63:0] m;
        logic [63:0] st;
        m = active_mask();
        st = m & (~m + 64'd1);
        cur_value = '0;
        if (cfg_first < cfg_last)
        begin
            if (cfg_mode == MODE_INC)
                cur_value = cfg_last * st;
            else if (cfg_mode == MODE_DEC)
                cur_value = cfg_first * st;
        end
        beat_count = '0;
    endtask

    // Advance the field for one accepted beat and queue the expected result
    task automatic step_field(input logic [63:0] word, input hdr_words_t hdr);
        logic [63:0]   m;
        logic [63:0]   st;
        logic [63:0]   lo;
        logic [63:0]   hi;
        logic [63:0]   fv;
        logic          rng;
        field_result_t r;
        m   = active_mask();
        st  = m & (~m + 64'd1);
        lo  = cfg_first * st;
        hi  = cfg_last * st;
        rng = cfg_first < cfg_last;
        case (cfg_mode)
            MODE_INC:
            begin
                cur_value = m & (cur_value + st);
                if (rng && (cur_value > hi || cur_value < lo))
                    cur_value = lo;
            end
            MODE_DEC:
            begin
                cur_value = m & (cur_value - st);
                if (rng && (cur_value > hi || cur_value < lo))
                    cur_value = hi;
            end
            MODE_CSUM: cur_value = {header_checksum(hdr), 48'd0};
            default: ; // hold the value
        endcase
        fv      = cur_value & m;
        r.word  = (word & ~m) | fv;
        r.value = fv;
        r.fire  = (cfg_period == '0) ? 1'b0 : ((beat_count % cfg_period) == '0);
        beat_count++;
        due_results.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        if (fail_count < 40)
            $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, exp_val);
        fail_count++;
    endtask

    initial
    begin
        fail_count      = 0;
        results_pending = 0;
        results_seen    = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_mode   = MODE_INC;
            cfg_mask   = FIELD_MASK_RST;
            cfg_first  = '0;
            cfg_last   = '0;
            cfg_period = '0;
            reload_start();
            due_results.delete();
        end
        else
        begin
            // compare the result beat against the oldest expectation
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (due_results.size() == 0)
                begin
                    report_mismatch("result beat with nothing expected", packet_word_out, '0);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (packet_word_out !== want.word)
                        report_mismatch("packet_word_out", packet_word_out, want.word);
                    if (field_value !== want.value)
                        report_mismatch("field_value", field_value, want.value);
                    if (chain_fire !== want.fire)
                        report_mismatch("chain_fire", {63'd0, chain_fire}, {63'd0, want.fire});
                end
            end
            // track register writes
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[5:3])
                    REG_MODE:
                    begin
                        cfg_mode = pwdata[1:0];
                        reload_start();
                    end
                    REG_FIELD_MASK:
                    begin
                        cfg_mask = pwdata;
                        reload_start();
                    end
                    REG_RANGE_FIRST:
                    begin
                        cfg_first = pwdata;
                        reload_start();
                    end
                    REG_RANGE_LAST:
                    begin
                        cfg_last = pwdata;
                        reload_start();
                    end
                    REG_CHAIN_PERIOD:
                    begin
                        cfg_period = pwdata[31:0];
                        reload_start();
                    end
                    default: ; // unmapped address, drop
                endcase
            end
            // predict the accepted input beat
            if (in_valid && !in_stall)
                step_field(packet_word, hdr_words);
        end
        results_pending = due_results.size();
    end

endmodule

// ----- tb/packet_field_stepper_tb.sv -----
// Top of the packet field stepper testbench: clock, reset, stimulus and verdict.
module packet_field_stepper_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pfs_pkg::*;

    localparam logic [1:0] MODE_HOLD    = 2'd3;
    localparam int         CYCLE_LIMIT  = 200_000;
    localparam int         DRAIN_CYCLES = 4;
    localparam int         RANDOM_BEATS = 700;

    typedef struct packed {
        logic [63:0] word;
        hdr_words_t  hdr;
    } pkt_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [63:0] packet_word = '0;
    logic [15:0] hdr_word_a = '0;
    logic [15:0] hdr_word_b = '0;
    logic [15:0] hdr_word_c = '0;
    logic [15:0] hdr_word_d = '0;
    logic [15:0] hdr_word_e = '0;
    logic [15:0] hdr_word_f = '0;
    logic [15:0] hdr_word_g = '0;
    logic [15:0] hdr_word_h = '0;
    logic [15:0] hdr_word_i = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] packet_word_out;
    logic [63:0] field_value;
    logic        chain_fire;

    int fail_count;
    int results_pending;
    int results_seen;
    int beats_sent = 0;
    int settings_loaded = 0;
    int cycle_count = 0;
    int burst_left = 0;
    int stall_window = 0;
    int stall_style = 0;
    logic [7:0] stall_phase = '0;

    packet_field_stepper u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .packet_word     (packet_word),
        .hdr_word_a      (hdr_word_a),
        .hdr_word_b      (hdr_word_b),
        .hdr_word_c      (hdr_word_c),
        .hdr_word_d      (hdr_word_d),
        .hdr_word_e      (hdr_word_e),
        .hdr_word_f      (hdr_word_f),
        .hdr_word_g      (hdr_word_g),
        .hdr_word_h      (hdr_word_h),
        .hdr_word_i      (hdr_word_i),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .packet_word_out (packet_word_out),
        .field_value     (field_value),
        .chain_fire      (chain_fire)
    );

    packet_field_stepper_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .packet_word     (packet_word),
        .hdr_words       ({hdr_word_i, hdr_word_h, hdr_word_g, hdr_word_f, hdr_word_e,
                           hdr_word_d, hdr_word_c, hdr_word_b, hdr_word_a}),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .packet_word_out (packet_word_out),
        .field_value     (field_value),
        .chain_fire      (chain_fire),
        .fail_count      (fail_count),
        .results_pending (results_pending),
        .results_seen    (results_seen)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, results_pending);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver stall: switch between free, random, periodic and long-hold styles
    always @(negedge clk)
    begin
        if (stall_window == 0)
        begin
            stall_style  = $urandom_range(0, 3);
            stall_window = $urandom_range(20, 120);
        end
        stall_window--;
        stall_phase++;
        case (stall_style)
            0:       out_stall = 1'b0;
            1:       out_stall = ($urandom_range(0, 2) == 0);
            2:       out_stall = (stall_phase[1:0] == 2'b11);
            default: out_stall = (stall_phase[3:0] >= 4'd10);
        endcase
    end

    // Drive one beat and hold it until accepted; called and returns at a falling edge
    task automatic send_beat(input logic [63:0] word, input hdr_words_t hdr);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        packet_word = word;
        {hdr_word_i, hdr_word_h, hdr_word_g, hdr_word_f, hdr_word_e,
         hdr_word_d, hdr_word_c, hdr_word_b, hdr_word_a} = hdr;
        in_valid = 1'b1;
        do @(posedge clk); while (in_stall);
        beats_sent++;
        @(negedge clk);
    endtask

    // Drop valid and wait for every expected result, then let the pipe empty
    task automatic wait_idle();
        in_valid = 1'b0;
        while (results_pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [63:0] value);
        paddr   = {idx, 3'b000};
        pwdata  = value;
        pwrite  = 1'b1;
        psel    = 1'b1;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Program all registers while the block is idle
    task automatic load_settings(input logic [1:0] mode, input logic [63:0] mask,
                                 input logic [63:0] first, input logic [63:0] last,
                                 input logic [31:0] period);
        wait_idle();
        reg_write(REG_MODE, {62'd0, mode});
        reg_write(REG_FIELD_MASK, mask);
        reg_write(REG_RANGE_FIRST, first);
        reg_write(REG_RANGE_LAST, last);
        reg_write(REG_CHAIN_PERIOD, {32'd0, period});
        settings_loaded++;
        // let the derived bounds settle
        repeat (2) @(negedge clk);
    endtask

    function automatic pkt_beat_t random_beat();
        pkt_beat_t b;
        case ($urandom_range(0, 9))
            0:       b.word = '0;
            1:       b.word = '1;
            default: b.word = {$urandom, $urandom};
        endcase
        for (int k = 0; k < 9; k++)
            b.hdr[k] = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535));
        return b;
    endfunction

    function automatic logic [63:0] random_mask();
        int unsigned width;
        int unsigned pos;
        logic [63:0] m;
        case ($urandom_range(0, 9))
            0: m = '0;
            1: m = '1;
            2: m = {$urandom, $urandom};
            default:
            begin
                width = $urandom_range(1, 64);
                pos   = $urandom_range(0, 64 - width);
                m     = (width == 64) ? '1 : (((64'd1 << width) - 64'd1) << pos);
            end
        endcase
        return m;
    endfunction

    // Random register settings followed by a run of beats
    task automatic random_phase(input int count, input bit pause_midway);
        logic [1:0]  mode;
        logic [63:0] first;
        logic [63:0] last;
        logic [31:0] period;
        pkt_beat_t   b;
        int          pick;
        pick = $urandom_range(0, 11);
        mode = (pick < 4) ? MODE_INC : (pick < 8) ? MODE_DEC :
               (pick < 11) ? MODE_CSUM : MODE_HOLD;
        case ($urandom_range(0, 9))
            6:
            begin
                first = '0;
                last  = '0;
            end
            7:
            begin
                last  = 64'($urandom_range(0, 20));
                first = last + 64'($urandom_range(1, 9));
            end
            8:
            begin
                first = {$urandom, $urandom};
                last  = {$urandom, $urandom};
            end
            9:
            begin
                last  = '1;
                first = last - 64'($urandom_range(1, 9));
            end
            default:
            begin
                first = 64'($urandom_range(0, 20));
                last  = first + 64'($urandom_range(1, 12));
            end
        endcase
        case ($urandom_range(0, 5))
            0:       period = '0;
            1:       period = 32'd1;
            2:       period = 32'hFFFF_FFFF;
            3:       period = $urandom;
            default: period = $urandom_range(2, 7);
        endcase
        load_settings(mode, random_mask(), first, last, period);
        for (int n = 0; n < count; n++)
        begin
            // hold off the sender until the block has drained
            if (pause_midway && n == count / 2)
                wait_idle();
            b = random_beat();
            send_beat(b.word, b.hdr);
        end
    endtask

    initial
    begin
        int        phase_idx;
        pkt_beat_t seed_beat;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings: increment over the top 32 bits
        send_beat('0, '0);
        send_beat('1, '1);
        seed_beat = random_beat();
        send_beat(64'h0123_4567_89AB_CDEF, seed_beat.hdr);

        // increment through a range and wrap back to its first value
        load_settings(MODE_INC, 64'h0000_0000_0000_FF00, 64'd3, 64'd5, 32'd2);
        repeat (4) send_beat({$urandom, $urandom}, '0);

        // decrement below the range and wrap to its last value
        load_settings(MODE_DEC, 64'h0000_0000_0000_FF00, 64'd3, 64'd5, 32'd1);
        repeat (3) send_beat({$urandom, $urandom}, '0);

        // checksum: zero header, all-ones header (deep carry fold), typical header
        load_settings(MODE_CSUM, '0, '0, '0, 32'd1);
        send_beat('1, '0);
        send_beat('0, '1);
        send_beat({$urandom, $urandom},
                  {16'h00C7, 16'hC0A8, 16'h0001, 16'hC0A8, 16'h4011,
                   16'h4000, 16'h0000, 16'h0073, 16'h4500});

        // mode three holds the value
        load_settings(MODE_HOLD, 64'h00FF_0000_0000_0000, '0, '0, 32'd3);
        repeat (2) send_beat('1, '0);

        // empty mask passes the word through
        load_settings(MODE_INC, '0, '0, '0, '0);
        repeat (2) send_beat({$urandom, $urandom}, '0);

        // mask with holes, decrement wraps from zero
        load_settings(MODE_DEC, 64'h0F0F_0000_0000_00F0, '0, '0, 32'hFFFF_FFFF);
        repeat (3) send_beat('1, '0);

        // first above last leaves the range off
        load_settings(MODE_INC, '1, 64'd9, 64'd2, '0);
        repeat (2) send_beat({$urandom, $urandom}, '0);

        // range bounds whose products wrap past 64 bits
        load_settings(MODE_INC, 64'hFF00_0000_0000_0000, 64'd1,
                      64'h0200_0000_0000_0001, '0);
        repeat (2) send_beat({$urandom, $urandom}, '0);

        // random settings and beats
        phase_idx = 0;
        while (beats_sent < RANDOM_BEATS + 24)
        begin
            random_phase($urandom_range(20, 90), phase_idx == 2);
            phase_idx++;
        end

        wait_idle();
        $display("Summary: %0d beats in, %0d results compared, %0d register settings",
                 beats_sent, results_seen, settings_loaded);
        $display("Summary: stepping up and down with ranges, checksum, hold, sparse masks");
        if (fail_count == 0 && results_pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
